[design/wies_pkg.sv]
`timescale 1ns / 1ps

package wies_pkg;

    localparam int MAX_SSID_BYTES = 32;
    localparam int IDX_W = (MAX_SSID_BYTES > 1) ? $clog2(MAX_SSID_BYTES) : 1;
    localparam int CNT_W = $clog2(MAX_SSID_BYTES + 1);
    localparam int LEN_W = 6;

    localparam logic [1:0] PH_TAG  = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [1:0] SS_NONE   = 2'd0;
    localparam logic [1:0] SS_HIDDEN = 2'd1;
    localparam logic [1:0] SS_TAKEN  = 2'd2;

    localparam logic [7:0] TAG_SSID   = 8'd0;
    localparam logic [7:0] TAG_RSN    = 8'd48;
    localparam logic [7:0] TAG_VENDOR = 8'd221;
    localparam int         PRIVACY_BIT = 4;
    localparam logic [7:0] WPA_MIN_LEN = 8'd4;

    localparam logic [1:0] SEC_OPEN = 2'd0;
    localparam logic [1:0] SEC_WEP  = 2'd1;
    localparam logic [1:0] SEC_WPA  = 2'd2;
    localparam logic [1:0] SEC_RSN  = 2'd3;

    // Run description handed from the parser to the emitter on the last byte.
    typedef struct packed {
        logic             start;
        logic             hidden;
        logic [CNT_W-1:0] count;
        logic [1:0]       sec;
    } run_req_t;

    function automatic logic [7:0] wpa_prefix(input logic [1:0] pos);
        logic [7:0] val;
        case (pos)
            2'd0:    val = 8'h00;
            2'd1:    val = 8'h50;
            2'd2:    val = 8'hf2;
            2'd3:    val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

[design/wies_in_if.sv]
`timescale 1ns / 1ps

interface wies_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  ie_byte;
    logic [15:0] capability;
    logic        final_byte;

    modport source (output valid, output ie_byte, output capability, output final_byte,
                    input ready);
    modport sink (input valid, input ie_byte, input capability, input final_byte,
                  output ready);
endinterface

[design/wies_out_if.sv]
`timescale 1ns / 1ps

interface wies_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] ssid_char;
    logic       char_valid;
    logic       is_hidden;
    logic [5:0] ssid_length;
    logic [1:0] security_class;
    logic       run_end;

    modport source (output valid, output ssid_char, output char_valid, output is_hidden,
                    output ssid_length, output security_class, output run_end,
                    input ready);
    modport sink (input valid, input ssid_char, input char_valid, input is_hidden,
                  input ssid_length, input security_class, input run_end,
                  output ready);
endinterface

[design/wies_ram.sv]
`timescale 1ns / 1ps

module wies_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/wies_parser.sv]
`timescale 1ns / 1ps

module wies_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            ie_byte,
    input  logic [15:0]           capability,
    input  logic                  final_byte,
    output logic                  wr_en,
    output logic [wies_pkg::IDX_W-1:0] wr_addr,
    output logic [7:0]            wr_data,
    output wies_pkg::run_req_t    run_req
);
    import wies_pkg::*;

    logic [1:0]       phase_reg, phase_next;
    logic [7:0]       tag_reg, tag_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       pos_reg, pos_next;
    logic             oui_reg, oui_next;
    logic             first_nz_reg, first_nz_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       status_reg, status_next;
    logic             rsn_reg, rsn_next;
    logic             wpa_reg, wpa_next;
    logic             finish;
    logic [8:0]       pos_inc;

    assign pos_inc = {1'b0, pos_reg} + 9'd1;
    assign wr_data = ie_byte;
    assign wr_addr = pos_reg[IDX_W-1:0];
    assign wr_en   = accept && (phase_reg == PH_BODY) && (tag_reg == TAG_SSID)
                     && (status_reg == SS_NONE) && ({1'b0, pos_reg} < 9'(MAX_SSID_BYTES));

    always_comb
    begin
        phase_next    = phase_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        oui_next      = oui_reg;
        first_nz_next = first_nz_reg;
        cnt_next      = cnt_reg;
        status_next   = status_reg;
        rsn_next      = rsn_reg;
        wpa_next      = wpa_reg;
        finish        = 1'b0;
        run_req       = '0;

        if (accept)
        begin
            case (phase_reg)
                PH_TAG:
                begin
                    tag_next   = ie_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next   = ie_byte;
                    pos_next   = 8'd0;
                    oui_next   = 1'b1;
                    phase_next = PH_BODY;
                    finish     = (ie_byte == 8'd0);
                end
                PH_BODY:
                begin
                    if (wr_en && (pos_reg == 8'd0))
                    begin
                        first_nz_next = (ie_byte != 8'd0);
                    end
                    if ((pos_reg < 8'd4) && (ie_byte != wpa_prefix(pos_reg[1:0])))
                    begin
                        oui_next = 1'b0;
                    end
                    pos_next = pos_inc[7:0];
                    finish   = (pos_inc >= {1'b0, len_reg});
                end
                default:
                begin
                    phase_next = PH_TAG;
                end
            endcase

            // The element is complete: apply its effect.
            if (finish)
            begin
                phase_next = PH_TAG;
                if (tag_next == TAG_SSID)
                begin
                    if (status_reg == SS_NONE)
                    begin
                        if (len_next == 8'd0)
                        begin
                            status_next = SS_HIDDEN;
                        end
                        else if (first_nz_next)
                        begin
                            status_next = SS_TAKEN;
                            cnt_next = (len_next > 8'(MAX_SSID_BYTES))
                                       ? CNT_W'(MAX_SSID_BYTES) : CNT_W'(len_next);
                        end
                    end
                end
                else if (tag_next == TAG_RSN)
                begin
                    rsn_next = 1'b1;
                end
                else if ((tag_next == TAG_VENDOR) && (len_next >= WPA_MIN_LEN) && oui_next)
                begin
                    wpa_next = 1'b1;
                end
            end

            if (final_byte)
            begin
                run_req.start  = 1'b1;
                run_req.hidden = !((status_next == SS_TAKEN) && (cnt_next != '0));
                run_req.count  = cnt_next;
                if (rsn_next)
                    run_req.sec = SEC_RSN;
                else if (wpa_next)
                    run_req.sec = SEC_WPA;
                else if (capability[PRIVACY_BIT])
                    run_req.sec = SEC_WEP;
                else
                    run_req.sec = SEC_OPEN;

                // Clear the per-buffer state for the next frame.
                phase_next    = PH_TAG;
                tag_next      = '0;
                len_next      = '0;
                pos_next      = '0;
                oui_next      = 1'b0;
                first_nz_next = 1'b0;
                cnt_next      = '0;
                status_next   = SS_NONE;
                rsn_next      = 1'b0;
                wpa_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TAG;
            tag_reg      <= '0;
            len_reg      <= '0;
            pos_reg      <= '0;
            oui_reg      <= 1'b0;
            first_nz_reg <= 1'b0;
            cnt_reg      <= '0;
            status_reg   <= SS_NONE;
            rsn_reg      <= 1'b0;
            wpa_reg      <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            tag_reg      <= tag_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            oui_reg      <= oui_next;
            first_nz_reg <= first_nz_next;
            cnt_reg      <= cnt_next;
            status_reg   <= status_next;
            rsn_reg      <= rsn_next;
            wpa_reg      <= wpa_next;
        end
    end

endmodule

[design/wies_emit.sv]
`timescale 1ns / 1ps

module wies_emit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wies_pkg::run_req_t         run_req,
    output logic                       busy,
    output logic [wies_pkg::IDX_W-1:0] rd_addr,
    input  logic [7:0]                 rd_data,
    wies_out_if.source                 results
);
    import wies_pkg::*;

    logic             busy_reg, busy_next;
    logic             hidden_reg, hidden_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       sec_reg, sec_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] raddr_reg, raddr_next;
    logic             pend_reg, pend_next;
    logic             ov_reg, ov_next;
    logic [7:0]       char_reg, char_next;
    logic             cv_reg, cv_next;
    logic             hid_out_reg, hid_out_next;
    logic [LEN_W-1:0] len_out_reg, len_out_next;
    logic [1:0]       sec_out_reg, sec_out_next;
    logic             end_reg, end_next;
    logic             out_free;
    logic             load;
    logic             issue;
    logic             last_pend;

    assign out_free  = !ov_reg || results.ready;
    assign load      = pend_reg && out_free;
    assign issue     = busy_reg && !hidden_reg && (idx_reg < cnt_reg) && (!pend_reg || load);
    assign last_pend = (CNT_W'(raddr_reg) == (cnt_reg - CNT_W'(1)));
    // The RAM keeps returning the last issued entry while a read waits.
    assign rd_addr   = issue ? idx_reg[IDX_W-1:0] : raddr_reg;
    assign busy      = busy_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        hidden_next  = hidden_reg;
        cnt_next     = cnt_reg;
        sec_next     = sec_reg;
        idx_next     = idx_reg;
        raddr_next   = raddr_reg;
        pend_next    = pend_reg;
        ov_next      = ov_reg;
        char_next    = char_reg;
        cv_next      = cv_reg;
        hid_out_next = hid_out_reg;
        len_out_next = len_out_reg;
        sec_out_next = sec_out_reg;
        end_next     = end_reg;

        if (ov_reg && results.ready)
        begin
            ov_next = 1'b0;
        end

        if (run_req.start)
        begin
            busy_next   = 1'b1;
            hidden_next = run_req.hidden;
            cnt_next    = run_req.count;
            sec_next    = run_req.sec;
            idx_next    = '0;
            pend_next   = 1'b0;
        end
        else if (busy_reg && hidden_reg)
        begin
            if (out_free)
            begin
                ov_next      = 1'b1;
                char_next    = 8'd0;
                cv_next      = 1'b0;
                hid_out_next = 1'b1;
                len_out_next = '0;
                sec_out_next = sec_reg;
                end_next     = 1'b1;
                busy_next    = 1'b0;
            end
        end
        else
        begin
            if (load)
            begin
                ov_next      = 1'b1;
                char_next    = rd_data;
                cv_next      = 1'b1;
                hid_out_next = 1'b0;
                len_out_next = LEN_W'(cnt_reg);
                sec_out_next = sec_reg;
                end_next     = last_pend;
                pend_next    = 1'b0;
                if (last_pend)
                begin
                    busy_next = 1'b0;
                end
            end
            if (issue)
            begin
                raddr_next = idx_reg[IDX_W-1:0];
                idx_next   = idx_reg + CNT_W'(1);
                pend_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            hidden_reg <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            raddr_reg  <= '0;
            pend_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            hidden_reg <= hidden_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            raddr_reg  <= raddr_next;
            pend_reg   <= pend_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sec_reg     <= sec_next;
        char_reg    <= char_next;
        cv_reg      <= cv_next;
        hid_out_reg <= hid_out_next;
        len_out_reg <= len_out_next;
        sec_out_reg <= sec_out_next;
        end_reg     <= end_next;
    end

    assign results.valid          = ov_reg;
    assign results.ssid_char      = char_reg;
    assign results.char_valid     = cv_reg;
    assign results.is_hidden      = hid_out_reg;
    assign results.ssid_length    = len_out_reg;
    assign results.security_class = sec_out_reg;
    assign results.run_end        = end_reg;

endmodule

[design/wlan_info_element_scanner_top.sv]
`timescale 1ns / 1ps

// Channel    Role    Payload
// bytes_in   sink    ie_byte, capability, final_byte
// results    source  ssid_char, char_valid, is_hidden, ssid_length, security_class, run_end
//
// Element bytes are taken one per cycle unless the emitter is busy; the first 32 body bytes
// of each SSID element met before one is taken or found hidden go into a 32-entry SSID RAM.
// On the final byte the input stalls while the run is read back: one result per cycle
// when the sink keeps ready high; the input is held until the run's last result is loaded.
// Reset clears all parser and emitter control state; the RAM needs no clearing.
module wlan_info_element_scanner_top (
    input logic        clk,
    input logic        rst_n,
    wies_in_if.sink    bytes_in,
    wies_out_if.source results
);
    import wies_pkg::*;

    logic             accept;
    logic             busy;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    run_req_t         run_req;

    assign bytes_in.ready = !busy;
    assign accept         = bytes_in.valid && !busy;

    wies_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .ie_byte    (bytes_in.ie_byte),
        .capability (bytes_in.capability),
        .final_byte (bytes_in.final_byte),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .run_req    (run_req)
    );

    wies_ram #(
        .WIDTH (8),
        .DEPTH (MAX_SSID_BYTES)
    ) u_ssid_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    wies_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .run_req (run_req),
        .busy    (busy),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .results (results)
    );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import wies_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_REPORTS  = 10;

    // Vendor element body prefix that marks WPA: OUI 00:50:F2, type 1.
    localparam logic [31:0] WPA_OUI_TYPE = 32'h0050f201;

    typedef struct packed {
        logic [7:0] ssid_char;
        logic       char_valid;
        logic       is_hidden;
        logic [5:0] ssid_length;
        logic [1:0] security_class;
        logic       run_end;
    } scan_result_t;

    class beacon_scan_checker;
        scan_result_t pending_chars[$];
        int           errors;

        logic [1:0] walk_phase;
        logic [7:0] elem_tag;
        logic [7:0] elem_len;
        logic [7:0] body_pos;
        logic       oui_ok;
        logic [7:0] ssid_bytes [MAX_SSID_BYTES];
        logic [5:0] ssid_cnt;
        logic [1:0] ssid_state;
        logic       rsn_flag;
        logic       wpa_flag;

        function new();
            errors = 0;
            foreach (ssid_bytes[i])
            begin
                ssid_bytes[i] = 8'h00;
            end
            start_new_buffer();
        endfunction

        function void start_new_buffer();
            walk_phase = PH_TAG;
            elem_tag   = 8'h00;
            elem_len   = 8'h00;
            body_pos   = 8'h00;
            oui_ok     = 1'b0;
            ssid_cnt   = 6'd0;
            ssid_state = SS_NONE;
            rsn_flag   = 1'b0;
            wpa_flag   = 1'b0;
        endfunction

        function void close_element();
            if (elem_tag == TAG_SSID)
            begin
                if (ssid_state == SS_NONE)
                begin
                    if (elem_len == 8'd0)
                        ssid_state = SS_HIDDEN;
                    else if (ssid_bytes[0] != 8'h00)
                    begin
                        // An SSID starting with a zero byte leaves the slot open.
                        ssid_state = SS_TAKEN;
                        ssid_cnt   = (elem_len > MAX_SSID_BYTES) ? 6'(MAX_SSID_BYTES)
                                                                 : 6'(elem_len);
                    end
                end
            end
            else if (elem_tag == TAG_RSN)
                rsn_flag = 1'b1;
            else if (elem_tag == TAG_VENDOR && elem_len >= WPA_MIN_LEN && oui_ok)
                wpa_flag = 1'b1;
            walk_phase = PH_TAG;
        endfunction

        function void take_ie_byte(logic [7:0] b, logic [15:0] cap, logic fin);
            scan_result_t r;
            logic [1:0]   sec;
            int           p;
            case (walk_phase)
                PH_TAG:
                begin
                    elem_tag   = b;
                    walk_phase = PH_LEN;
                end
                PH_LEN:
                begin
                    elem_len = b;
                    body_pos = 8'd0;
                    oui_ok   = 1'b1;
                    if (b == 8'd0)
                        close_element();
                    else
                        walk_phase = PH_BODY;
                end
                default:
                begin
                    p = body_pos;
                    if (elem_tag == TAG_SSID && ssid_state == SS_NONE && p < MAX_SSID_BYTES)
                        ssid_bytes[p] = b;
                    if (p < 4 && b != WPA_OUI_TYPE[31 - 8 * p -: 8])
                        oui_ok = 1'b0;
                    body_pos = body_pos + 8'd1;
                    if (body_pos >= elem_len)
                        close_element();
                end
            endcase

            if (fin)
            begin
                if (rsn_flag)
                    sec = SEC_RSN;
                else if (wpa_flag)
                    sec = SEC_WPA;
                else if (cap[PRIVACY_BIT])
                    sec = SEC_WEP;
                else
                    sec = SEC_OPEN;

                if (ssid_state == SS_TAKEN && ssid_cnt != 6'd0)
                begin
                    for (int k = 0; k < ssid_cnt; k++)
                    begin
                        r.ssid_char      = ssid_bytes[k];
                        r.char_valid     = 1'b1;
                        r.is_hidden      = 1'b0;
                        r.ssid_length    = ssid_cnt;
                        r.security_class = sec;
                        r.run_end        = (k == ssid_cnt - 1);
                        pending_chars.push_back(r);
                    end
                end
                else
                begin
                    r = '{8'h00, 1'b0, 1'b1, 6'd0, sec, 1'b1};
                    pending_chars.push_back(r);
                end
                start_new_buffer();
            end
        endfunction

        function string show(scan_result_t r);
            return $sformatf("char=%02h valid=%0d hidden=%0d len=%0d sec=%0d end=%0d",
                             r.ssid_char, r.char_valid, r.is_hidden, r.ssid_length,
                             r.security_class, r.run_end);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_char(scan_result_t got);
            scan_result_t want;
            if (pending_chars.size() == 0)
            begin
                flag({"result with nothing expected: ", show(got)});
                return;
            end
            want = pending_chars.pop_front();
            if (got.ssid_char !== want.ssid_char || got.char_valid !== want.char_valid ||
                got.is_hidden !== want.is_hidden || got.ssid_length !== want.ssid_length ||
                got.security_class !== want.security_class || got.run_end !== want.run_end)
                flag({"result mismatch: expected ", show(want), ", got ", show(got)});
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count = 0;
    int   send_idle_pct;
    int   stall_pct;

    logic [7:0] frame_bytes[$];
    beacon_scan_checker scan_chk;

    wies_in_if  bytes_in ();
    wies_out_if results ();

    wlan_info_element_scanner_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes_in (bytes_in),
        .results  (results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Receiver: ready changes only at the falling edge.
    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : monitor
        scan_result_t seen;
        if (rst_n && bytes_in.valid && bytes_in.ready)
            scan_chk.take_ie_byte(bytes_in.ie_byte, bytes_in.capability, bytes_in.final_byte);
        if (rst_n && results.valid && results.ready)
        begin
            seen = '{results.ssid_char, results.char_valid, results.is_hidden,
                     results.ssid_length, results.security_class, results.run_end};
            scan_chk.check_char(seen);
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(input logic [7:0] b, input logic [15:0] cap, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            bytes_in.valid      = 1'b0;
            bytes_in.ie_byte    = 8'($urandom);
            bytes_in.final_byte = 1'($urandom);
            @(negedge clk);
        end
        bytes_in.valid      = 1'b1;
        bytes_in.ie_byte    = b;
        bytes_in.capability = cap;
        bytes_in.final_byte = fin;
        @(posedge clk);
        while (!bytes_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // The capability word only matters on the final byte; the others carry noise.
    task automatic send_frame(input logic [15:0] cap_word);
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            if (i == frame_bytes.size() - 1)
                send_byte(frame_bytes[i], cap_word, 1'b1);
            else
                send_byte(frame_bytes[i], 16'($urandom), 1'b0);
        end
    endtask

    function automatic void add_random_element();
        int         pick;
        int         len;
        logic [7:0] tag;
        logic [7:0] body_byte;
        pick = $urandom_range(9);
        if (pick <= 2)
        begin
            tag = TAG_SSID;
            case ($urandom_range(5))
                0:       len = 0;
                1:       len = $urandom_range(31, 40);
                default: len = $urandom_range(1, 8);
            endcase
        end
        else if (pick == 3)
        begin
            tag = TAG_RSN;
            len = $urandom_range(0, 4);
        end
        else if (pick <= 5)
        begin
            tag = TAG_VENDOR;
            len = $urandom_range(2, 8);
        end
        else
        begin
            tag = 8'($urandom);
            len = $urandom_range(0, 6);
        end
        frame_bytes.push_back(tag);
        frame_bytes.push_back(8'(len));
        for (int i = 0; i < len; i++)
        begin
            body_byte = 8'($urandom);
            if (tag == TAG_VENDOR && i < 4 && $urandom_range(7) != 0)
                body_byte = WPA_OUI_TYPE[31 - 8 * i -: 8];
            if (tag == TAG_SSID && i == 0 && $urandom_range(3) == 0)
                body_byte = 8'h00;
            frame_bytes.push_back(body_byte);
        end
    endfunction

    function automatic void build_random_frame();
        int keep;
        frame_bytes.delete();
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 12))
                frame_bytes.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                add_random_element();
            // Cut some buffers short so the last element may be left incomplete.
            if ($urandom_range(4) == 0)
            begin
                keep = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > keep)
                    void'(frame_bytes.pop_back());
            end
        end
    endfunction

    task automatic run_random_phase(input int idle_pct, input int hold_pct, input int budget);
        int          sent;
        logic [15:0] cap_word;
        sent          = 0;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        while (sent < budget)
        begin
            build_random_frame();
            case ($urandom_range(3))
                0:       cap_word = 16'h0000;
                1:       cap_word = 16'hffff;
                default: cap_word = 16'($urandom);
            endcase
            sent += frame_bytes.size();
            send_frame(cap_word);
        end
    endtask

    initial
    begin
        scan_chk            = new();
        rst_n               = 1'b0;
        bytes_in.valid      = 1'b0;
        bytes_in.ie_byte    = 8'h00;
        bytes_in.capability = 16'h0000;
        bytes_in.final_byte = 1'b0;
        send_idle_pct       = 0;
        stall_pct           = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Buffer ends right after a tag byte; privacy bit set.
        frame_bytes = '{TAG_SSID};
        send_frame(16'hffff);
        // An empty SSID locks the hidden case even though a real SSID follows.
        frame_bytes = '{TAG_SSID, 8'd0, TAG_SSID, 8'd2, 8'h61, 8'h62};
        send_frame(16'h0000);
        // SSID starting with zero is skipped, the next one is taken, then RSN.
        frame_bytes = '{TAG_SSID, 8'd1, 8'h00, TAG_SSID, 8'd2, 8'hff, 8'h80, TAG_RSN, 8'd0};
        send_frame(16'h0000);
        // A complete WPA vendor element ends the buffer.
        frame_bytes = '{TAG_VENDOR, 8'd4, 8'h00, 8'h50, 8'hf2, 8'h01};
        send_frame(16'h0000);
        // A vendor element too short to mark WPA.
        frame_bytes = '{TAG_VENDOR, 8'd3, 8'h00, 8'h50, 8'hf2};
        send_frame(16'hffef);
        // SSID element cut off by the end of the buffer.
        frame_bytes = '{TAG_SSID, 8'd5, 8'h78};
        send_frame(16'h0010);

        run_random_phase(0, 0, 80);
        run_random_phase(52, 0, 80);
        run_random_phase(0, 52, 80);
        run_random_phase(18, 18, 80);
        bytes_in.valid = 1'b0;

        while (scan_chk.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (scan_chk.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
